// ===== design/ucfp_pkg.sv =====
// Shared types and constants for the UART command frame parser.
`default_nettype none

package ucfp_pkg;

    // Register defaults and command code range
    localparam logic [7:0] HEADER_RESET  = 8'hAA;
    localparam logic [7:0] TRAILER_RESET = 8'h55;
    localparam logic [7:0] CMD_MIN       = 8'h01;
    localparam logic [7:0] CMD_MAX       = 8'h05;
    localparam logic [2:0] CMD_NONE      = 3'd0;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEADER  = 1'b0,
        CFG_TRAILER = 1'b1
    } cfg_index_t;

    // Frame position, one-hot
    typedef enum logic [8:0] {
        POS_HDR  = 9'b000000001,
        POS_CMD  = 9'b000000010,
        POS_SPDH = 9'b000000100,
        POS_SPDL = 9'b000001000,
        POS_PLSH = 9'b000010000,
        POS_PLSL = 9'b000100000,
        POS_DIR  = 9'b001000000,
        POS_TRL  = 9'b010000000,
        POS_CHK  = 9'b100000000
    } pos_t;

    // One result beat
    typedef struct packed {
        logic        frame_valid;
        logic        checksum_error;
        logic [2:0]  command;
        logic        direction;
        logic [15:0] speed;
        logic [15:0] pulse_count;
    } result_t;

endpackage

`default_nettype wire

// ===== design/ucfp_if.sv =====
// Valid/ready channel interfaces for received bytes and parser results.
`default_nettype none

interface ucfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfp_out_if;
    logic        valid;
    logic        ready;
    logic        frame_valid;
    logic        checksum_error;
    logic [2:0]  command;
    logic        direction;
    logic [15:0] speed;
    logic [15:0] pulse_count;

    modport source (output valid, output frame_valid, output checksum_error,
                    output command, output direction, output speed,
                    output pulse_count, input ready);
    modport sink   (input valid, input frame_valid, input checksum_error,
                    input command, input direction, input speed,
                    input pulse_count, output ready);
endinterface

`default_nettype wire

// ===== design/uart_command_frame_parser.sv =====
// Top level: nine-byte command frame parser with a registered result beat.
// A result beat is registered from each accepted byte and appears in the cycle after it.
// Throughput: one byte per cycle; a byte is taken whenever the result register
// is empty or its beat is being taken in the same cycle.
// Reset: rst_n clears the frame state, latched fields and registers to their
// defaults (header 0xAA, trailer 0x55) at once; no clearing pass.
`default_nettype none

module uart_command_frame_parser
    import ucfp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data,
    ucfp_in_if.sink                     byte_ch,
    ucfp_out_if.source                  result_ch
);

    // Configuration registers
    logic [7:0] header_reg;
    logic [7:0] trailer_reg;

    // Frame state
    pos_t        pos_reg,        pos_next;
    logic [7:0]  sum_reg,        sum_next;
    logic [2:0]  cmd_reg,        cmd_next;
    logic        dir_reg,        dir_next;
    logic [15:0] speed_part_reg, speed_part_next;
    logic [15:0] pulse_part_reg, pulse_part_next;
    logic [15:0] speed_lat_reg,  speed_lat_next;
    logic [15:0] pulse_lat_reg,  pulse_lat_next;

    // Result register
    logic    out_valid_reg;
    result_t res_reg, res_next;

    logic       accept;
    logic [7:0] rx;

    assign rx            = byte_ch.rx_byte;
    assign byte_ch.ready = !out_valid_reg || result_ch.ready;
    assign accept        = byte_ch.valid && byte_ch.ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HEADER_RESET;
            trailer_reg <= TRAILER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER:  header_reg  <= cfg_data;
                CFG_TRAILER: trailer_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Decode one byte against the frame position
    always_comb
    begin
        pos_next        = POS_HDR;
        sum_next        = sum_reg;
        cmd_next        = cmd_reg;
        dir_next        = dir_reg;
        speed_part_next = speed_part_reg;
        pulse_part_next = pulse_part_reg;
        speed_lat_next  = speed_lat_reg;
        pulse_lat_next  = pulse_lat_reg;
        res_next        = '0;

        case (pos_reg)
            POS_HDR:
            begin
                if (rx == header_reg)
                begin
                    sum_next = rx;
                    pos_next = POS_CMD;
                end
            end
            POS_CMD:
            begin
                if (rx inside {[CMD_MIN:CMD_MAX]})
                begin
                    cmd_next = rx[2:0];
                end
                sum_next = sum_reg + rx;
                pos_next = POS_SPDH;
            end
            POS_SPDH:
            begin
                speed_part_next = {rx, speed_part_reg[7:0]};
                sum_next        = sum_reg + rx;
                pos_next        = POS_SPDL;
            end
            POS_SPDL:
            begin
                speed_part_next = {speed_part_reg[15:8], rx};
                sum_next        = sum_reg + rx;
                pos_next        = POS_PLSH;
            end
            POS_PLSH:
            begin
                pulse_part_next = {rx, pulse_part_reg[7:0]};
                sum_next        = sum_reg + rx;
                pos_next        = POS_PLSL;
            end
            POS_PLSL:
            begin
                pulse_part_next = {pulse_part_reg[15:8], rx};
                sum_next        = sum_reg + rx;
                pos_next        = POS_DIR;
            end
            POS_DIR:
            begin
                // Direction takes effect here even if the frame fails later
                if (rx inside {8'd0, 8'd1})
                begin
                    dir_next = rx[0];
                    sum_next = sum_reg + rx;
                    pos_next = POS_TRL;
                end
            end
            POS_TRL:
            begin
                if (rx == trailer_reg)
                begin
                    sum_next = sum_reg + rx;
                    pos_next = POS_CHK;
                end
            end
            POS_CHK:
            begin
                if (rx == sum_reg)
                begin
                    speed_lat_next       = speed_part_reg;
                    pulse_lat_next       = pulse_part_reg;
                    res_next.frame_valid = 1'b1;
                end
                else
                begin
                    res_next.checksum_error = 1'b1;
                end
            end
            default:
            begin
                pos_next = POS_HDR;
            end
        endcase

        // Report the command before a completed frame clears it
        res_next.command     = cmd_next;
        res_next.direction   = dir_next;
        res_next.speed       = speed_lat_next;
        res_next.pulse_count = pulse_lat_next;
        if (res_next.frame_valid)
        begin
            cmd_next = CMD_NONE;
        end
    end

    // Advance frame state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_HDR;
            sum_reg        <= '0;
            cmd_reg        <= CMD_NONE;
            dir_reg        <= 1'b0;
            speed_part_reg <= '0;
            pulse_part_reg <= '0;
            speed_lat_reg  <= '0;
            pulse_lat_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            cmd_reg        <= cmd_next;
            dir_reg        <= dir_next;
            speed_part_reg <= speed_part_next;
            pulse_part_reg <= pulse_part_next;
            speed_lat_reg  <= speed_lat_next;
            pulse_lat_reg  <= pulse_lat_next;
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.frame_valid    = res_reg.frame_valid;
    assign result_ch.checksum_error = res_reg.checksum_error;
    assign result_ch.command        = res_reg.command;
    assign result_ch.direction      = res_reg.direction;
    assign result_ch.speed          = res_reg.speed;
    assign result_ch.pulse_count    = res_reg.pulse_count;

    // Checks
    a_pos_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(pos_reg))
        else $error("frame position lost its one-hot code");

    a_chk_returns: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (pos_reg == POS_CHK) |=> (pos_reg == POS_HDR))
        else $error("checksum byte did not return the parser to the start");

    a_valid_clears_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_next.frame_valid |=> (cmd_reg == CMD_NONE))
        else $error("stored command not cleared after a valid frame");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.frame_valid && res_reg.checksum_error))
        else $error("frame_valid and checksum_error raised together");

endmodule

`default_nettype wire
